/* sv/burf_pkg.sv */
// ============================================================================
// Buffered UART ring FIFOs - shared definitions
// Depths, pointer widths, request codes and the controller command bundle.
// ============================================================================
package burf_pkg;

    // Ring sizes. Each ring keeps one slot empty, so it holds depth minus one.
    localparam int unsigned RX_DEPTH = 64;
    localparam int unsigned TX_DEPTH = 64;

    // Pointer widths follow from the ring sizes.
    localparam int unsigned RX_AW = $clog2(RX_DEPTH);
    localparam int unsigned TX_AW = $clog2(TX_DEPTH);

    // Width of the receive count reported with every result.
    localparam int unsigned RX_COUNT_W = 6;

    // Request kinds carried in the func field.
    typedef enum logic [1:0] {
        FUNC_HOST_WRITE = 2'd0,
        FUNC_HOST_READ  = 2'd1,
        FUNC_SERVICE    = 2'd2,
        FUNC_UNUSED     = 2'd3
    } func_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming transaction
        logic execute;   // update rings and pointers, start memory reads
        logic load_out;  // fill the result register
    } burf_cmd_t;

endpackage

/* sv/buffered_uart_ring_fifos_unit.sv */
// ============================================================================
// Buffered UART ring FIFOs - top level
// Receive and transmit ring FIFOs of a buffered serial port behind one
// request channel and one result channel.
// ============================================================================
// Each request transaction is a host write, a host read or a service event,
// and yields exactly one result transaction that reports the outcome and the
// receive count after the step. The accepting edge captures the request,
// then the rings are updated while the ring memories are read, and then the
// registered read data is loaded into the result register, which makes the
// result valid. The next request is taken the cycle after the load, so the
// block does not take a new request before the last one is through. It
// takes that next request even when the previous result has not yet been
// taken, and then holds it in the final step until the result register is
// free. A full ring holds depth minus one bytes and drops further bytes,
// which the result flags report.
module buffered_uart_ring_fifos_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_func,
    input  logic [7:0]                      s_host_byte,
    input  logic                            s_line_valid,
    input  logic [7:0]                      s_line_byte,
    input  logic                            s_tx_idle,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_read_byte,
    output logic                            m_read_ok,
    output logic                            m_write_dropped,
    output logic                            m_rx_dropped,
    output logic                            m_send_valid,
    output logic [7:0]                      m_send_byte,
    output logic                            m_tx_irq_on,
    output logic [burf_pkg::RX_COUNT_W-1:0] m_rx_count
);

    burf_pkg::burf_cmd_t cmd;

    // Sequencing and handshakes.
    burf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Rings, pointers and result register.
    burf_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_func          (s_func),
        .s_host_byte     (s_host_byte),
        .s_line_valid    (s_line_valid),
        .s_line_byte     (s_line_byte),
        .s_tx_idle       (s_tx_idle),
        .m_read_byte     (m_read_byte),
        .m_read_ok       (m_read_ok),
        .m_write_dropped (m_write_dropped),
        .m_rx_dropped    (m_rx_dropped),
        .m_send_valid    (m_send_valid),
        .m_send_byte     (m_send_byte),
        .m_tx_irq_on     (m_tx_irq_on),
        .m_rx_count      (m_rx_count)
    );

endmodule

/* sv/burf_ctrl.sv */
// ============================================================================
// Buffered UART ring FIFOs - controller
// Sequences one transaction through capture, execute and result load, and
// owns the handshake flags of both channels.
// ============================================================================
module burf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output burf_pkg::burf_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Commands decoded from the current state and the handshakes.
    always_comb begin
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.execute  = (state_reg == ST_EXEC);
        cmd.load_out = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    end

    // Next state and result-valid flag.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered handshake flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* sv/burf_datapath.sv */
// ============================================================================
// Buffered UART ring FIFOs - datapath
// Holds both ring memories, their pointers, the transmit-interrupt enable,
// the captured request and the result register.
// ============================================================================
module burf_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  burf_pkg::burf_cmd_t                 cmd,
    input  logic [1:0]                          s_func,
    input  logic [7:0]                          s_host_byte,
    input  logic                                s_line_valid,
    input  logic [7:0]                          s_line_byte,
    input  logic                                s_tx_idle,
    output logic [7:0]                          m_read_byte,
    output logic                                m_read_ok,
    output logic                                m_write_dropped,
    output logic                                m_rx_dropped,
    output logic                                m_send_valid,
    output logic [7:0]                          m_send_byte,
    output logic                                m_tx_irq_on,
    output logic [burf_pkg::RX_COUNT_W-1:0]     m_rx_count
);

    localparam int unsigned RX_AW = burf_pkg::RX_AW;
    localparam int unsigned TX_AW = burf_pkg::TX_AW;
    localparam int unsigned RX_LW = RX_AW + 1;
    localparam int unsigned CNT_W = burf_pkg::RX_COUNT_W;
    localparam int unsigned EXT_W = (RX_LW > CNT_W) ? RX_LW : CNT_W;

    // Captured request.
    burf_pkg::func_t func_reg;
    logic [7:0]      host_byte_reg;
    logic            line_valid_reg;
    logic [7:0]      line_byte_reg;
    logic            tx_idle_reg;

    // Ring memories and read data.
    logic [7:0] rx_mem [burf_pkg::RX_DEPTH];
    logic [7:0] tx_mem [burf_pkg::TX_DEPTH];
    logic [7:0] rx_rdata_reg;
    logic [7:0] tx_rdata_reg;

    // Pointers and enable.
    logic [RX_AW-1:0] rx_wr_ptr_reg, rx_wr_ptr_next;
    logic [RX_AW-1:0] rx_rd_ptr_reg, rx_rd_ptr_next;
    logic [TX_AW-1:0] tx_wr_ptr_reg, tx_wr_ptr_next;
    logic [TX_AW-1:0] tx_rd_ptr_reg, tx_rd_ptr_next;
    logic             tx_irq_reg, tx_irq_next;

    // Outcome flags of the executed request.
    logic read_ok_reg, read_ok_next;
    logic write_dropped_reg, write_dropped_next;
    logic rx_dropped_reg, rx_dropped_next;
    logic send_valid_reg, send_valid_next;

    // Memory write strobes.
    logic rx_we;
    logic tx_we;

    // Advanced pointers and ring status.
    logic [RX_AW-1:0] rx_wr_adv, rx_rd_adv;
    logic [TX_AW-1:0] tx_wr_adv, tx_rd_adv;
    logic             rx_full, rx_empty, tx_full, tx_empty;

    // Receive level after the step.
    logic [RX_LW-1:0] rx_level;
    logic [EXT_W-1:0] rx_level_ext;

    // Pointer increments with wrap at the ring size.
    always_comb begin
        rx_wr_adv = (rx_wr_ptr_reg == RX_AW'(burf_pkg::RX_DEPTH - 1)) ?
                    '0 : rx_wr_ptr_reg + RX_AW'(1);
        rx_rd_adv = (rx_rd_ptr_reg == RX_AW'(burf_pkg::RX_DEPTH - 1)) ?
                    '0 : rx_rd_ptr_reg + RX_AW'(1);
        tx_wr_adv = (tx_wr_ptr_reg == TX_AW'(burf_pkg::TX_DEPTH - 1)) ?
                    '0 : tx_wr_ptr_reg + TX_AW'(1);
        tx_rd_adv = (tx_rd_ptr_reg == TX_AW'(burf_pkg::TX_DEPTH - 1)) ?
                    '0 : tx_rd_ptr_reg + TX_AW'(1);
        rx_full   = (rx_wr_adv == rx_rd_ptr_reg);
        tx_full   = (tx_wr_adv == tx_rd_ptr_reg);
        rx_empty  = (rx_wr_ptr_reg == rx_rd_ptr_reg);
        tx_empty  = (tx_wr_ptr_reg == tx_rd_ptr_reg);
    end

    // Request decode: ring updates for the executing transaction.
    always_comb begin
        rx_wr_ptr_next     = rx_wr_ptr_reg;
        rx_rd_ptr_next     = rx_rd_ptr_reg;
        tx_wr_ptr_next     = tx_wr_ptr_reg;
        tx_rd_ptr_next     = tx_rd_ptr_reg;
        tx_irq_next        = tx_irq_reg;
        read_ok_next       = 1'b0;
        write_dropped_next = 1'b0;
        rx_dropped_next    = 1'b0;
        send_valid_next    = 1'b0;
        rx_we              = 1'b0;
        tx_we              = 1'b0;
        unique case (func_reg)
            burf_pkg::FUNC_HOST_WRITE: begin
                if (tx_full) begin
                    write_dropped_next = 1'b1;
                end else begin
                    tx_we          = 1'b1;
                    tx_wr_ptr_next = tx_wr_adv;
                    tx_irq_next    = 1'b1;
                end
            end
            burf_pkg::FUNC_HOST_READ: begin
                if (!rx_empty) begin
                    read_ok_next   = 1'b1;
                    rx_rd_ptr_next = rx_rd_adv;
                end
            end
            burf_pkg::FUNC_SERVICE: begin
                if (line_valid_reg) begin
                    if (rx_full) begin
                        rx_dropped_next = 1'b1;
                    end else begin
                        rx_we          = 1'b1;
                        rx_wr_ptr_next = rx_wr_adv;
                    end
                end
                if (tx_idle_reg && tx_irq_reg) begin
                    if (!tx_empty) begin
                        send_valid_next = 1'b1;
                        tx_rd_ptr_next  = tx_rd_adv;
                    end else begin
                        tx_irq_next = 1'b0;
                    end
                end
            end
            default: begin
                // Unused code: no state changes.
            end
        endcase
    end

    // Capture of the incoming transaction.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg       <= burf_pkg::func_t'(s_func);
            host_byte_reg  <= s_host_byte;
            line_valid_reg <= s_line_valid;
            line_byte_reg  <= s_line_byte;
            tx_idle_reg    <= s_tx_idle;
        end
    end

    // Ring memories: one write and one registered read each.
    always_ff @(posedge aclk) begin
        if (cmd.execute && rx_we) begin
            rx_mem[rx_wr_ptr_reg] <= line_byte_reg;
        end
        if (cmd.execute) begin
            rx_rdata_reg <= rx_mem[rx_rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && tx_we) begin
            tx_mem[tx_wr_ptr_reg] <= host_byte_reg;
        end
        if (cmd.execute) begin
            tx_rdata_reg <= tx_mem[tx_rd_ptr_reg];
        end
    end

    // Pointers and interrupt enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_wr_ptr_reg <= '0;
            rx_rd_ptr_reg <= '0;
            tx_wr_ptr_reg <= '0;
            tx_rd_ptr_reg <= '0;
            tx_irq_reg    <= 1'b0;
        end else if (cmd.execute) begin
            rx_wr_ptr_reg <= rx_wr_ptr_next;
            rx_rd_ptr_reg <= rx_rd_ptr_next;
            tx_wr_ptr_reg <= tx_wr_ptr_next;
            tx_rd_ptr_reg <= tx_rd_ptr_next;
            tx_irq_reg    <= tx_irq_next;
        end
    end

    // Outcome flags, held until the result register is loaded.
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            read_ok_reg       <= read_ok_next;
            write_dropped_reg <= write_dropped_next;
            rx_dropped_reg    <= rx_dropped_next;
            send_valid_reg    <= send_valid_next;
        end
    end

    // Receive level from the updated pointers.
    always_comb begin
        if (rx_wr_ptr_reg >= rx_rd_ptr_reg) begin
            rx_level = {1'b0, rx_wr_ptr_reg} - {1'b0, rx_rd_ptr_reg};
        end else begin
            rx_level = {1'b0, rx_wr_ptr_reg} + RX_LW'(burf_pkg::RX_DEPTH)
                       - {1'b0, rx_rd_ptr_reg};
        end
        rx_level_ext = EXT_W'(rx_level);
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_read_byte     <= read_ok_reg ? rx_rdata_reg : 8'd0;
            m_read_ok       <= read_ok_reg;
            m_write_dropped <= write_dropped_reg;
            m_rx_dropped    <= rx_dropped_reg;
            m_send_valid    <= send_valid_reg;
            m_send_byte     <= send_valid_reg ? tx_rdata_reg : 8'd0;
            m_tx_irq_on     <= tx_irq_reg;
            m_rx_count      <= rx_level_ext[CNT_W-1:0];
        end
    end

endmodule

/* sv/burf_checker.sv */
// ============================================================================
// Buffered UART ring FIFOs - port checker
// Watches the top-level ports for handshake and result consistency.
// ============================================================================
module burf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [7:0]                      m_read_byte,
    input logic                            m_read_ok,
    input logic                            m_write_dropped,
    input logic                            m_rx_dropped,
    input logic                            m_send_valid,
    input logic [7:0]                      m_send_byte,
    input logic [burf_pkg::RX_COUNT_W-1:0] m_rx_count
);

    // A stalled result transaction holds its payload.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_byte)
            && $stable(m_send_byte) && $stable(m_rx_count))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in work");

    // A host read outcome never mixes with write or service outcomes.
    a_single_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_ok |-> !m_write_dropped && !m_rx_dropped && !m_send_valid)
        else $error("result reports more than one request kind");

    // Data bytes are zero when no byte is reported.
    a_zero_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_read_ok || m_read_byte == 8'd0)
            && (m_send_valid || m_send_byte == 8'd0))
        else $error("nonzero data byte without a byte reported");

endmodule

bind buffered_uart_ring_fifos_unit burf_checker u_burf_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_read_byte     (m_read_byte),
    .m_read_ok       (m_read_ok),
    .m_write_dropped (m_write_dropped),
    .m_rx_dropped    (m_rx_dropped),
    .m_send_valid    (m_send_valid),
    .m_send_byte     (m_send_byte),
    .m_rx_count      (m_rx_count)
);
